@@ sv/crc16_frame_receive_checker_assert.svh @@
`ifndef CRC16_FRAME_RECEIVE_CHECKER_ASSERT_SVH
`define CRC16_FRAME_RECEIVE_CHECKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CRC16FRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("crc16frc check failed");

// next-cycle implication, disabled in reset
`define CRC16FRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("crc16frc check failed");

`endif

@@ sv/crc16frc_pkg.sv @@
package crc16frc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;

    localparam logic [7:0] DELIMITER_RESET   = 8'd192;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

    // position of the last byte of a frame with no payload
    localparam logic [15:0] MIN_LAST_POS  = 16'd7;
    localparam logic [15:0] LAST_HDR_POS  = 16'd4;
    localparam logic [15:0] POS_SATURATED = 16'hFFFF;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_SHORT        = 3'd1,
        STATUS_BAD_DELIM    = 3'd2,
        STATUS_LEN_OVER_MAX = 3'd3,
        STATUS_LEN_MISMATCH = 3'd4,
        STATUS_CRC_MISMATCH = 3'd5
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [7:0]   payload_byte;
        logic [7:0]   frame_src;
        logic [7:0]   frame_dst;
        logic [7:0]   command_id;
        logic [7:0]   payload_len;
        status_t      status;
    } out_item_t;

endpackage

@@ sv/crc16frc_crc.sv @@
module crc16frc_crc (
    input  logic [15:0] crc_in,
    input  logic [7:0]  byte_in,
    output logic [15:0] crc_out
);
    import crc16frc_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {byte_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

@@ sv/crc16_frame_receive_checker.sv @@
// Frame receive checker: takes one frame byte per item (delimiter, source,
// destination, command, length, payload, CRC high, CRC low, delimiter) and
// passes each payload byte out as it arrives; the item flagged end_of_frame
// yields one status item with the header and the first failing check. The
// block accepts one byte every cycle and registers each result; s_ready drops
// only while a result waits in the output register and m_ready is low. The
// per-byte path is the eight-step CRC-16 (0x8005, init 0) update plus the
// position compares, all between the frame state registers and the output
// register.
module crc16_frame_receive_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  crc16frc_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output crc16frc_pkg::out_item_t                m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [crc16frc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                             cfg_data
);
    import crc16frc_pkg::*;

    logic [7:0]  delim_reg, max_len_reg;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic        start_reg, start_next;
    logic        m_valid_reg;
    out_item_t   m_data_reg, m_data_next;
    logic        emit;
    logic        s_fire;
    logic [15:0] crc_upd;
    logic [15:0] pay_end;
    logic        first_ok;
    status_t     st;

    crc16frc_crc u_crc (
        .crc_in  (crc_reg),
        .byte_in (s_data.rx_byte),
        .crc_out (crc_upd)
    );

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign pay_end   = LAST_HDR_POS + {8'h00, len_reg};

    always_comb begin
        first_ok = (pos_reg == 16'h0000) ? (s_data.rx_byte == delim_reg) : start_reg;
        if (pos_reg < MIN_LAST_POS) begin
            st = STATUS_SHORT;
        end else if (!first_ok || s_data.rx_byte != delim_reg) begin
            st = STATUS_BAD_DELIM;
        end else if (len_reg > max_len_reg) begin
            st = STATUS_LEN_OVER_MAX;
        end else if (pos_reg != MIN_LAST_POS + {8'h00, len_reg}) begin
            st = STATUS_LEN_MISMATCH;
        end else if (crc_reg != rx_crc_reg) begin
            st = STATUS_CRC_MISMATCH;
        end else begin
            st = STATUS_OK;
        end
    end

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        src_next    = src_reg;
        dest_next   = dest_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        rx_crc_next = rx_crc_reg;
        start_next  = start_reg;
        emit        = 1'b0;
        m_data_next = '0;
        if (s_fire) begin
            if (s_data.end_of_frame) begin
                emit                    = 1'b1;
                m_data_next.result_kind = KIND_STATUS;
                m_data_next.frame_src   = src_reg;
                m_data_next.frame_dst   = dest_reg;
                m_data_next.command_id  = cmd_reg;
                m_data_next.payload_len = len_reg;
                m_data_next.status      = st;
                pos_next    = '0;
                crc_next    = CRC_INIT;
                src_next    = '0;
                dest_next   = '0;
                cmd_next    = '0;
                len_next    = '0;
                rx_crc_next = '0;
                start_next  = 1'b0;
            end else begin
                if (pos_reg != POS_SATURATED) begin
                    pos_next = pos_reg + 16'd1;
                end
                if (pos_reg == 16'h0000) begin
                    start_next = (s_data.rx_byte == delim_reg);
                end else if (pos_reg <= LAST_HDR_POS) begin
                    case (pos_reg[2:0])
                        3'd1:    src_next  = s_data.rx_byte;
                        3'd2:    dest_next = s_data.rx_byte;
                        3'd3:    cmd_next  = s_data.rx_byte;
                        default: len_next  = s_data.rx_byte;
                    endcase
                    crc_next = crc_upd;
                end else if (pos_reg <= pay_end) begin
                    crc_next                 = crc_upd;
                    emit                     = 1'b1;
                    m_data_next.result_kind  = KIND_PAYLOAD;
                    m_data_next.payload_byte = s_data.rx_byte;
                end else if (pos_reg == pay_end + 16'd1) begin
                    rx_crc_next = {s_data.rx_byte, rx_crc_reg[7:0]};
                end else if (pos_reg == pay_end + 16'd2) begin
                    rx_crc_next = {rx_crc_reg[15:8], s_data.rx_byte};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg   <= DELIMITER_RESET;
            max_len_reg <= MAX_PAYLOAD_RESET;
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            src_reg     <= '0;
            dest_reg    <= '0;
            cmd_reg     <= '0;
            len_reg     <= '0;
            rx_crc_reg  <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_DELIMITER:   delim_reg   <= cfg_data;
                    CFG_MAX_PAYLOAD: max_len_reg <= cfg_data;
                    default: ;
                endcase
            end
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            src_reg    <= src_next;
            dest_reg   <= dest_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            rx_crc_reg <= rx_crc_next;
            start_reg  <= start_next;
            if (s_fire) begin
                m_valid_reg <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            m_data_reg <= m_data_next;
        end
    end

`include "crc16_frame_receive_checker_assert.svh"

    `CRC16FRC_ASSERT_NEXT(a_eof_clears_pos, aclk, aresetn, s_fire && s_data.end_of_frame, pos_reg == 16'h0000 && !start_reg)
    `CRC16FRC_ASSERT_NEXT(a_eof_gives_status, aclk, aresetn, s_fire && s_data.end_of_frame, m_valid_reg && m_data_reg.result_kind == KIND_STATUS)
    `CRC16FRC_ASSERT_NOW(a_empty_takes_item, aclk, aresetn, !m_valid_reg, s_ready)
    `CRC16FRC_ASSERT_NOW(a_start_after_first, aclk, aresetn, start_reg, pos_reg != 16'h0000)

endmodule

@@ tb/crc16_frame_receive_checker_test.sv @@
`timescale 1ns / 100ps

module crc16_frame_receive_checker_test;
    import crc16frc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 270;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    crc16_frame_receive_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    in_item_t  frame_bytes_q[$];
    out_item_t awaited_results[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   err_count      = 0;
    int   idle_cycles    = 0;
    int   queued_count   = 0;
    logic byte_taken     = 1'b0;

    logic [7:0] delim_now  = DELIMITER_RESET;
    logic [7:0] maxpay_now = MAX_PAYLOAD_RESET;

    logic [7:0]  pred_delim = DELIMITER_RESET;
    logic [7:0]  pred_max   = MAX_PAYLOAD_RESET;
    logic [15:0] frame_pos  = '0;
    logic [15:0] frame_crc  = CRC_INIT;
    logic [15:0] rx_crc     = '0;
    logic [7:0]  hdr_src    = '0;
    logic [7:0]  hdr_dest   = '0;
    logic [7:0]  hdr_cmd    = '0;
    logic [7:0]  hdr_len    = '0;
    logic        opened_ok  = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void restart_frame();
        frame_pos = '0;
        frame_crc = CRC_INIT;
        rx_crc    = '0;
        hdr_src   = '0;
        hdr_dest  = '0;
        hdr_cmd   = '0;
        hdr_len   = '0;
        opened_ok = 1'b0;
    endfunction

    function automatic void track_frame_byte(in_item_t it);
        out_item_t r;
        int        pos_n;
        int        pay_last;
        logic      first_ok;
        r        = '0;
        pos_n    = int'(frame_pos);
        pay_last = int'(LAST_HDR_POS) + int'(hdr_len);
        if (it.end_of_frame) begin
            first_ok      = (pos_n == 0) ? (it.rx_byte == pred_delim) : opened_ok;
            r.result_kind = KIND_STATUS;
            r.frame_src   = hdr_src;
            r.frame_dst   = hdr_dest;
            r.command_id  = hdr_cmd;
            r.payload_len = hdr_len;
            if (pos_n < MIN_LAST_POS)
                r.status = STATUS_SHORT;
            else if (!first_ok || it.rx_byte != pred_delim)
                r.status = STATUS_BAD_DELIM;
            else if (hdr_len > pred_max)
                r.status = STATUS_LEN_OVER_MAX;
            else if (pos_n != MIN_LAST_POS + hdr_len)
                r.status = STATUS_LEN_MISMATCH;
            else if (frame_crc != rx_crc)
                r.status = STATUS_CRC_MISMATCH;
            else
                r.status = STATUS_OK;
            awaited_results.push_back(r);
            restart_frame();
        end else begin
            if (pos_n == 0) begin
                opened_ok = (it.rx_byte == pred_delim);
            end else if (pos_n <= LAST_HDR_POS) begin
                case (pos_n)
                    1: hdr_src = it.rx_byte;
                    2: hdr_dest = it.rx_byte;
                    3: hdr_cmd = it.rx_byte;
                    default: hdr_len = it.rx_byte;
                endcase
                frame_crc = crc16_step(frame_crc, it.rx_byte);
            end else if (pos_n <= pay_last) begin
                frame_crc      = crc16_step(frame_crc, it.rx_byte);
                r.result_kind  = KIND_PAYLOAD;
                r.payload_byte = it.rx_byte;
                awaited_results.push_back(r);
            end else if (pos_n == pay_last + 1) begin
                rx_crc[15:8] = it.rx_byte;
            end else if (pos_n == pay_last + 2) begin
                rx_crc[7:0] = it.rx_byte;
            end
            if (frame_pos != POS_SATURATED)
                frame_pos = frame_pos + 16'd1;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            if (frame_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= frame_bytes_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : monitor
        out_item_t want;
        logic      in_fire;
        logic      out_fire;
        logic      cfg_fire;
        logic      busy;
        if (!aresetn) begin
            byte_taken = 1'b0;
            pred_delim = DELIMITER_RESET;
            pred_max   = MAX_PAYLOAD_RESET;
            restart_frame();
        end else begin
            in_fire    = s_valid && s_ready;
            out_fire   = m_valid && m_ready;
            cfg_fire   = cfg_valid && cfg_ready;
            byte_taken = in_fire;
            busy       = frame_bytes_q.size() != 0 || s_valid || cfg_valid ||
                         awaited_results.size() != 0;
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_DELIMITER:   pred_delim = cfg_data;
                    CFG_MAX_PAYLOAD: pred_max = cfg_data;
                    default: ;
                endcase
            end
            if (out_fire) begin
                if (awaited_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", 8'(want.result_kind), 8'(m_data.result_kind));
                    check_field("payload_byte", want.payload_byte, m_data.payload_byte);
                    check_field("frame_src", want.frame_src, m_data.frame_src);
                    check_field("frame_dst", want.frame_dst, m_data.frame_dst);
                    check_field("command_id", want.command_id, m_data.command_id);
                    check_field("payload_len", want.payload_len, m_data.payload_len);
                    check_field("status", 8'(want.status), 8'(m_data.status));
                end
            end
            if (in_fire)
                track_frame_byte(s_data);
            if (busy && !(in_fire || out_fire || cfg_fire))
                idle_cycles++;
            else
                idle_cycles = 0;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic build_frame(input logic [7:0] first_b, input logic [7:0] last_b,
                               input logic [7:0] src, input logic [7:0] dst,
                               input logic [7:0] cmd, input logic [7:0] len,
                               input int n_pay, input logic [15:0] crc_flip,
                               output in_item_t frm[$]);
        logic [15:0] crc;
        logic [7:0]  hdr [4];
        logic [7:0]  b;
        crc = CRC_INIT;
        hdr = '{src, dst, cmd, len};
        frm = {};
        frm.push_back({first_b, 1'b0});
        foreach (hdr[i]) begin
            frm.push_back({hdr[i], 1'b0});
            crc = crc16_step(crc, hdr[i]);
        end
        for (int i = 0; i < n_pay; i++) begin
            b = 8'($urandom_range(255));
            frm.push_back({b, 1'b0});
            crc = crc16_step(crc, b);
        end
        crc = crc ^ crc_flip;
        frm.push_back({crc[15:8], 1'b0});
        frm.push_back({crc[7:0], 1'b0});
        frm.push_back({last_b, 1'b1});
    endtask

    task automatic queue_frame(input logic [7:0] first_b, input logic [7:0] last_b,
                               input logic [7:0] src, input logic [7:0] dst,
                               input logic [7:0] cmd, input logic [7:0] len,
                               input int n_pay, input logic [15:0] crc_flip);
        in_item_t frm[$];
        build_frame(first_b, last_b, src, dst, cmd, len, n_pay, crc_flip, frm);
        foreach (frm[i]) frame_bytes_q.push_back(frm[i]);
        queued_count += frm.size();
    endtask

    task automatic queue_noise(input int n, input logic [7:0] first_b);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = (i == 0) ? first_b : 8'($urandom_range(255));
            frame_bytes_q.push_back({b, i == n - 1});
        end
        queued_count += n;
    endtask

    task automatic queue_random_frame();
        int         pick;
        int         len;
        int         n_pay;
        logic [7:0] first_b;
        logic [7:0] last_b;
        logic [7:0] flip_bit;
        logic [15:0] crc_flip;
        pick     = $urandom_range(99);
        len      = ($urandom_range(24) == 0) ? $urandom_range(255) : $urandom_range(10);
        first_b  = delim_now;
        last_b   = delim_now;
        crc_flip = 16'h0000;
        flip_bit = 8'd1 << $urandom_range(7);
        if (pick < 60 && len > maxpay_now)
            len = $urandom_range(maxpay_now);
        n_pay = len;
        if (pick >= 60 && pick < 70) begin
            crc_flip = 16'($urandom_range(65535, 1));
        end else if (pick >= 70 && pick < 78) begin
            n_pay = $urandom_range(len + 3);
            if (n_pay == len)
                n_pay = len + 1;
        end else if (pick >= 78 && pick < 86) begin
            if ($urandom_range(1))
                first_b = delim_now ^ flip_bit;
            else
                last_b = delim_now ^ flip_bit;
        end
        if (pick >= 93)
            queue_noise($urandom_range(20, 1), 8'($urandom_range(255)));
        else if (pick >= 86)
            queue_noise($urandom_range(7, 1), $urandom_range(1) ? delim_now : 8'($urandom_range(255)));
        else
            queue_frame(first_b, last_b, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'(len), n_pay, crc_flip);
    endtask

    task automatic settle();
        while (frame_bytes_q.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DELIMITER:   delim_now = val;
            CFG_MAX_PAYLOAD: maxpay_now = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(input int sidle, input int rstall);
        int start;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        start          = queued_count;
        while (queued_count - start < PHASE_ITEMS)
            queue_random_frame();
        settle();
    endtask

    initial begin
        in_item_t   frm[$];
        logic [7:0] d2;
        int         split;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        queue_frame(delim_now, delim_now, 8'h00, 8'hFF, 8'h00, 8'd0, 0, 16'h0000);
        queue_frame(delim_now, delim_now, 8'hFF, 8'h00, 8'hFF, 8'd2, 2, 16'h0000);
        queue_noise(1, delim_now);
        queue_noise(7, delim_now);
        queue_frame(delim_now ^ 8'h01, delim_now, 8'h11, 8'h22, 8'h33, 8'd0, 0, 16'h0000);
        queue_frame(delim_now, delim_now ^ 8'h80, 8'h44, 8'h55, 8'h66, 8'd0, 0, 16'h0000);
        queue_frame(delim_now, delim_now, 8'h77, 8'h88, 8'h99, 8'd1, 0, 16'h0000);
        queue_frame(delim_now, delim_now, 8'hAA, 8'hBB, 8'hCC, 8'd1, 1, 16'h8000);
        // overlong frame: far more payload bytes than declared
        queue_frame(delim_now, delim_now, 8'h5A, 8'hA5, 8'h3C, 8'd3, 20, 16'h0000);
        run_phase(0, 0);

        write_reg(CFG_SPARE_LO, 8'h00);
        write_reg(CFG_SPARE_HI, 8'hFF);
        queue_frame(delim_now, delim_now, 8'h01, 8'h02, 8'h03, 8'd2, 2, 16'h0000);
        settle();
        write_reg(CFG_DELIMITER, 8'h00);
        write_reg(CFG_MAX_PAYLOAD, 8'h00);
        queue_frame(delim_now, delim_now, 8'h0F, 8'hF0, 8'h5A, 8'd1, 1, 16'h0000);
        queue_frame(delim_now, delim_now, 8'hF0, 8'h0F, 8'hA5, 8'd0, 0, 16'h0000);
        run_phase(45, 0);

        write_reg(CFG_DELIMITER, 8'hFF);
        write_reg(CFG_MAX_PAYLOAD, 8'hFF);
        queue_frame(delim_now, delim_now, 8'hC3, 8'h3C, 8'h81, 8'd255, 255, 16'h0000);
        run_phase(0, 45);

        write_reg(CFG_DELIMITER, 8'($urandom_range(255)));
        write_reg(CFG_MAX_PAYLOAD, 8'($urandom_range(40, 4)));
        // change the delimiter while a frame is partly received
        d2 = delim_now ^ 8'h5A;
        build_frame(delim_now, d2, 8'h12, 8'h34, 8'h56, 8'd2, 2, 16'h0000, frm);
        split = 3;
        for (int i = 0; i < split; i++) frame_bytes_q.push_back(frm[i]);
        settle();
        write_reg(CFG_DELIMITER, d2);
        for (int i = split; i < frm.size(); i++) frame_bytes_q.push_back(frm[i]);
        run_phase(14, 14);

        repeat (8) @(posedge aclk);
        if (err_count == 0 && awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
